/* rtl/egcd_pkg.sv */
package egcd_pkg;

    // Operand width; coefficients carry one extra bit.
    localparam int WIDTH = 32;
    localparam int CW    = WIDTH + 1;
    localparam int CNT_W = $clog2(WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_UPD,
        S_OUT
    } t_state;

    // Start request and operands for the shared divide / multiply unit.
    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] num_mag;
        logic [WIDTH-1:0] den_mag;
        logic [CW-1:0]    s_mul;
        logic [CW-1:0]    t_mul;
    } t_div_ctl;

    // Unit results: remainder magnitude and quotient-times-coefficient products.
    typedef struct packed {
        logic             done;
        logic [WIDTH-1:0] rem;
        logic [CW-1:0]    ps;
        logic [CW-1:0]    pt;
    } t_div_res;

endpackage

/* rtl/extended_gcd_modular_inverse.sv */
// Extended Euclidean modular inverse. Each input word carries a signed value
// and a signed modulus; the block runs Euclid with floor-division quotients
// from remainders (value, modulus) and returns one output word: |gcd|, the
// Bezout coefficients of value and modulus (33-bit signed), and the inverse,
// which is the value coefficient plus the modulus once when that coefficient
// is negative. The gcd is not checked for 1. A zero modulus gives gcd=|value|,
// coefficients 1 and 0, inverse 1. Each Euclid step runs the bit-serial
// divider, which also forms the quotient products for both coefficients,
// then hands its result back, and is followed by an update state and a
// test state. Input stall is high from accept until the result is moved
// into the output register; a finished word may sit in the output
// register while the next item is taken.
module extended_gcd_modular_inverse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [egcd_pkg::WIDTH-1:0]    i_value_in,
    input  logic [egcd_pkg::WIDTH-1:0]    i_modulus_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [egcd_pkg::WIDTH-1:0]    o_gcd_out,
    output logic [egcd_pkg::CW-1:0]       o_coef_value,
    output logic [egcd_pkg::CW-1:0]       o_coef_modulus,
    output logic [egcd_pkg::CW-1:0]       o_inverse_out
);
    import egcd_pkg::*;

    t_state           r_state, n_state;
    logic [WIDTH-1:0] r_rc, n_rc;     // current remainder (signed)
    logic [WIDTH-1:0] r_rn, n_rn;     // next remainder (signed), the divisor
    logic [CW-1:0]    r_sc, n_sc;     // value coefficients
    logic [CW-1:0]    r_sn, n_sn;
    logic [CW-1:0]    r_tc, n_tc;     // modulus coefficients
    logic [CW-1:0]    r_tn, n_tn;
    logic [WIDTH-1:0] r_mod, n_mod;   // original modulus, for the inverse fix

    logic             r_ov, n_ov;
    logic [WIDTH-1:0] r_gcd, n_gcd;
    logic [CW-1:0]    r_cv, n_cv;
    logic [CW-1:0]    r_cm, n_cm;
    logic [CW-1:0]    r_inv, n_inv;

    t_div_ctl         div_ctl;
    t_div_res         div_res;
    logic             div_start;

    logic             in_acc;
    logic             out_acc;
    logic [WIDTH-1:0] num_mag;
    logic [WIDTH-1:0] den_mag;
    logic             nneg, dneg, diffsign, rz;
    logic [WIDTH-1:0] r_trunc, r_new;
    logic [CW-1:0]    sn_new, tn_new;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_ov && !i_out_stall;

    assign num_mag = r_rc[WIDTH-1] ? (~r_rc + WIDTH'(1)) : r_rc;
    assign den_mag = r_rn[WIDTH-1] ? (~r_rn + WIDTH'(1)) : r_rn;

    // Floor-division fix-up: the divider works on magnitudes (truncating);
    // when the signs differ and the remainder is nonzero the quotient drops
    // by one, the remainder takes the divisor's sign, and q*x loses one x.
    always_comb begin
        nneg     = r_rc[WIDTH-1];
        dneg     = r_rn[WIDTH-1];
        diffsign = nneg ^ dneg;
        rz       = (div_res.rem == '0);
        r_trunc  = nneg ? (~div_res.rem + WIDTH'(1)) : div_res.rem;
        r_new    = (diffsign && !rz) ? (r_trunc + r_rn) : r_trunc;
        if (diffsign) begin
            sn_new = r_sc + div_res.ps + (rz ? '0 : r_sn);
            tn_new = r_tc + div_res.pt + (rz ? '0 : r_tn);
        end else begin
            sn_new = r_sc - div_res.ps;
            tn_new = r_tc - div_res.pt;
        end
    end

    assign div_ctl.start   = div_start;
    assign div_ctl.num_mag = num_mag;
    assign div_ctl.den_mag = den_mag;
    assign div_ctl.s_mul   = r_sn;
    assign div_ctl.t_mul   = r_tn;

    egcd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .o_res   (div_res)
    );

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_rc       = r_rc;
        n_rn       = r_rn;
        n_sc       = r_sc;
        n_sn       = r_sn;
        n_tc       = r_tc;
        n_tn       = r_tn;
        n_mod      = r_mod;
        n_ov       = out_acc ? 1'b0 : r_ov;
        n_gcd      = r_gcd;
        n_cv       = r_cv;
        n_cm       = r_cm;
        n_inv      = r_inv;
        div_start  = 1'b0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rc    = i_value_in;
                    n_rn    = i_modulus_in;
                    n_mod   = i_modulus_in;
                    n_sc    = CW'(1);
                    n_sn    = '0;
                    n_tc    = '0;
                    n_tn    = CW'(1);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_rn == '0) begin
                    n_state = S_OUT;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_rc    = r_rn;
                n_rn    = r_new;
                n_sc    = r_sn;
                n_sn    = sn_new;
                n_tc    = r_tn;
                n_tn    = tn_new;
                n_state = S_CHECK;
            end
            S_OUT: begin
                // Output register free, or being emptied this cycle.
                if (!r_ov || !i_out_stall) begin
                    n_ov    = 1'b1;
                    n_gcd   = num_mag;
                    n_cv    = r_sc;
                    n_cm    = r_tc;
                    n_inv   = r_sc[CW-1] ? (r_sc + {r_mod[WIDTH-1], r_mod}) : r_sc;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_rc  <= n_rc;
        r_rn  <= n_rn;
        r_sc  <= n_sc;
        r_sn  <= n_sn;
        r_tc  <= n_tc;
        r_tn  <= n_tn;
        r_mod <= n_mod;
        r_gcd <= n_gcd;
        r_cv  <= n_cv;
        r_cm  <= n_cm;
        r_inv <= n_inv;
    end

    assign o_out_valid    = r_ov;
    assign o_gcd_out      = r_gcd;
    assign o_coef_value   = r_cv;
    assign o_coef_modulus = r_cm;
    assign o_inverse_out  = r_inv;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_CHECK))
        else $error("accepted word did not start a run");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_ctl.start |-> (r_rn != '0))
        else $error("divider started with zero divisor");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && n_state == S_IDLE) |=> r_ov)
        else $error("finished result not presented");

    a_upd_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (div_res.rem < den_mag))
        else $error("remainder not below divisor magnitude");

endmodule

/* rtl/egcd_divider.sv */
module egcd_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  egcd_pkg::t_div_ctl  i_ctl,
    output egcd_pkg::t_div_res  o_res
);
    import egcd_pkg::*;

    localparam logic [CNT_W-1:0] LAST = CNT_W'(WIDTH - 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [CW-1:0]    r_ps, n_ps;
    logic [CW-1:0]    r_pt, n_pt;

    logic [WIDTH:0]   trial;
    logic [WIDTH+1:0] diff;
    logic             qbit;

    // One restoring step per cycle, quotient bits MSB first; the products
    // Q*s and Q*t build up Horner style from the same bits.
    always_comb begin
        trial  = {r_rem, r_quo[WIDTH-1]};
        diff   = {1'b0, trial} - {2'b00, i_ctl.den_mag};
        qbit   = ~diff[WIDTH+1];
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_ps   = r_ps;
        n_pt   = r_pt;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_ctl.num_mag;
            n_rem  = '0;
            n_ps   = '0;
            n_pt   = '0;
        end else if (r_busy) begin
            n_quo = {r_quo[WIDTH-2:0], qbit};
            n_rem = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            n_ps  = {r_ps[CW-2:0], 1'b0} + (qbit ? i_ctl.s_mul : '0);
            n_pt  = {r_pt[CW-2:0], 1'b0} + (qbit ? i_ctl.t_mul : '0);
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_ps  <= n_ps;
        r_pt  <= n_pt;
    end

    assign o_res.done = r_done;
    assign o_res.rem  = r_rem;
    assign o_res.ps   = r_ps;
    assign o_res.pt   = r_pt;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> (r_rem < i_ctl.den_mag))
        else $error("partial remainder not below divisor");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_ctl.start)
        else $error("divider restarted while busy");

    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held longer than one cycle");

endmodule
